[sv/lzsd_pkg.sv]
package lzsd_pkg;

    localparam int HistDepth   = 512;
    localparam int PosBits     = 9;
    localparam int LenBits     = 4;
    localparam int MinMatch    = 2;
    localparam int LitBits     = 8;

    localparam int AddrW       = $clog2(HistDepth);
    localparam int AccW        = PosBits + LenBits;
    localparam int HeldW       = $clog2(AccW + 1);
    localparam int RemainW     = $clog2((1 << LenBits) + MinMatch);
    localparam int BitCntW     = 4;
    localparam int CountW      = 32;
    localparam int OutDataW    = LitBits + CountW;

    typedef struct packed {
        logic load;
        logic bit_step;
        logic mem_rd;
        logic copy_emit;
        logic report;
    } cmd_t;

    typedef struct packed {
        logic lit_done;
        logic match_done;
        logic last_bit;
        logic bits_done;
        logic copy_last;
        logic last_flag;
        logic out_free;
    } status_t;

endpackage

[sv/lzsd_ctrl.sv]
module lzsd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  lzsd_pkg::status_t status,
    output lzsd_pkg::cmd_t    cmd
);
    import lzsd_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BITS,
        ST_READ,
        ST_WRITE,
        ST_REPORT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_BITS;
                end
            end
            ST_BITS:
            begin
                if (!status.lit_done || status.out_free)
                begin
                    cmd.bit_step = 1'b1;
                    if (status.match_done)
                    begin
                        state_next = ST_READ;
                    end
                    else if (status.last_bit)
                    begin
                        state_next = status.last_flag ? ST_REPORT : ST_IDLE;
                    end
                end
            end
            ST_READ:
            begin
                cmd.mem_rd = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (status.out_free)
                begin
                    cmd.copy_emit = 1'b1;
                    if (!status.copy_last)
                    begin
                        state_next = ST_READ;
                    end
                    else if (!status.bits_done)
                    begin
                        state_next = ST_BITS;
                    end
                    else
                    begin
                        state_next = status.last_flag ? ST_REPORT : ST_IDLE;
                    end
                end
            end
            ST_REPORT:
            begin
                if (status.out_free)
                begin
                    cmd.report = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[sv/lzsd_datapath.sv]
module lzsd_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lzsd_pkg::cmd_t                cmd,
    output lzsd_pkg::status_t             status,
    input  logic [lzsd_pkg::LitBits-1:0]  in_byte,
    input  logic                          last_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [lzsd_pkg::LitBits-1:0]  out_byte,
    output logic                          is_data,
    output logic                          out_last,
    output logic [lzsd_pkg::CountW-1:0]   total_length
);
    import lzsd_pkg::*;

    typedef enum logic [1:0] {
        PH_FLAG,
        PH_LIT,
        PH_MATCH
    } phase_t;

    logic [LitBits-1:0] ring_mem [HistDepth];

    logic [LitBits-1:0] shift_reg, shift_next;
    logic [BitCntW-1:0] bitcnt_reg, bitcnt_next;
    logic               lastf_reg, lastf_next;
    phase_t             phase_reg, phase_next;
    logic [AccW-1:0]    acc_reg, acc_next;
    logic [HeldW-1:0]   held_reg, held_next;
    logic [AddrW-1:0]   wslot_reg, wslot_next;
    logic               wrapped_reg, wrapped_next;
    logic [CountW-1:0]  wcount_reg, wcount_next;
    logic [AddrW-1:0]   src_reg, src_next;
    logic [RemainW-1:0] remain_reg, remain_next;
    logic [LitBits-1:0] rdata_reg;
    logic               hit_reg;
    logic               ovalid_reg, ovalid_next;
    logic [LitBits-1:0] obyte_reg, obyte_next;
    logic               odata_reg, odata_next;
    logic               olast_reg, olast_next;
    logic [CountW-1:0]  olen_reg, olen_next;

    logic               cur_bit;
    logic [AccW-1:0]    acc_shift;
    logic [HeldW-1:0]   held_inc;
    logic               lit_done;
    logic               match_done;
    logic               out_free;
    logic               emit;
    logic [LitBits-1:0] emit_byte;
    logic [CountW-1:0]  wcount_inc;
    logic [PosBits-1:0] match_pos;

    assign cur_bit    = shift_reg[LitBits-1];
    assign acc_shift  = {acc_reg[AccW-2:0], cur_bit};
    assign held_inc   = held_reg + HeldW'(1);
    assign lit_done   = (phase_reg == PH_LIT) && (held_inc >= HeldW'(LitBits));
    assign match_done = (phase_reg == PH_MATCH) && (held_inc >= HeldW'(AccW));
    assign out_free   = !ovalid_reg || out_ready;
    assign wcount_inc = (wcount_reg == '1) ? wcount_reg : wcount_reg + CountW'(1);
    assign match_pos  = acc_shift[AccW-1:LenBits];

    assign emit      = (cmd.bit_step && lit_done) || cmd.copy_emit;
    assign emit_byte = cmd.copy_emit ? (hit_reg ? rdata_reg : '0) : acc_shift[LitBits-1:0];

    always_comb
    begin
        status.lit_done   = lit_done;
        status.match_done = match_done;
        status.last_bit   = (bitcnt_reg == BitCntW'(LitBits - 1));
        status.bits_done  = (bitcnt_reg == BitCntW'(LitBits));
        status.copy_last  = (remain_reg == RemainW'(1));
        status.last_flag  = lastf_reg;
        status.out_free   = out_free;
    end

    always_comb
    begin
        shift_next   = shift_reg;
        bitcnt_next  = bitcnt_reg;
        lastf_next   = lastf_reg;
        phase_next   = phase_reg;
        acc_next     = acc_reg;
        held_next    = held_reg;
        wslot_next   = wslot_reg;
        wrapped_next = wrapped_reg;
        wcount_next  = wcount_reg;
        src_next     = src_reg;
        remain_next  = remain_reg;
        ovalid_next  = ovalid_reg;
        obyte_next   = obyte_reg;
        odata_next   = odata_reg;
        olast_next   = olast_reg;
        olen_next    = olen_reg;

        if (ovalid_reg && out_ready)
        begin
            ovalid_next = 1'b0;
        end

        if (cmd.load)
        begin
            shift_next  = in_byte;
            bitcnt_next = '0;
            lastf_next  = last_byte;
        end

        if (cmd.bit_step)
        begin
            shift_next  = {shift_reg[LitBits-2:0], 1'b0};
            bitcnt_next = bitcnt_reg + BitCntW'(1);
            case (phase_reg)
                PH_LIT,
                PH_MATCH:
                begin
                    acc_next  = acc_shift;
                    held_next = held_inc;
                    if (lit_done || match_done)
                    begin
                        phase_next = PH_FLAG;
                        acc_next   = '0;
                        held_next  = '0;
                    end
                    if (match_done)
                    begin
                        src_next    = AddrW'(match_pos - PosBits'(1));
                        remain_next = RemainW'(acc_shift[LenBits-1:0]) + RemainW'(MinMatch);
                    end
                end
                default:
                begin
                    phase_next = cur_bit ? PH_LIT : PH_MATCH;
                    acc_next   = '0;
                    held_next  = '0;
                end
            endcase
        end

        if (cmd.copy_emit)
        begin
            src_next    = src_reg + AddrW'(1);
            remain_next = remain_reg - RemainW'(1);
        end

        if (emit)
        begin
            wslot_next = wslot_reg + AddrW'(1);
            if (wslot_reg == '1)
            begin
                wrapped_next = 1'b1;
            end
            wcount_next = wcount_inc;
            ovalid_next = 1'b1;
            obyte_next  = emit_byte;
            odata_next  = 1'b1;
            olast_next  = 1'b0;
            olen_next   = wcount_inc;
        end

        if (cmd.report)
        begin
            ovalid_next  = 1'b1;
            obyte_next   = '0;
            odata_next   = 1'b0;
            olast_next   = 1'b1;
            olen_next    = wcount_reg;
            wcount_next  = '0;
            wslot_next   = '0;
            wrapped_next = 1'b0;
            phase_next   = PH_FLAG;
            acc_next     = '0;
            held_next    = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            ring_mem[wslot_reg] <= emit_byte;
        end
        if (cmd.mem_rd)
        begin
            rdata_reg <= ring_mem[src_reg];
            hit_reg   <= wrapped_reg || (src_reg < wslot_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bitcnt_reg  <= '0;
            lastf_reg   <= 1'b0;
            phase_reg   <= PH_FLAG;
            acc_reg     <= '0;
            held_reg    <= '0;
            wslot_reg   <= '0;
            wrapped_reg <= 1'b0;
            wcount_reg  <= '0;
            remain_reg  <= '0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            bitcnt_reg  <= bitcnt_next;
            lastf_reg   <= lastf_next;
            phase_reg   <= phase_next;
            acc_reg     <= acc_next;
            held_reg    <= held_next;
            wslot_reg   <= wslot_next;
            wrapped_reg <= wrapped_next;
            wcount_reg  <= wcount_next;
            remain_reg  <= remain_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        src_reg   <= src_next;
        obyte_reg <= obyte_next;
        odata_reg <= odata_next;
        olast_reg <= olast_next;
        olen_reg  <= olen_next;
    end

    assign out_valid    = ovalid_reg;
    assign out_byte     = obyte_reg;
    assign is_data      = odata_reg;
    assign out_last     = olast_reg;
    assign total_length = olen_reg;

endmodule

[sv/lzss_stream_decoder_unit.sv]
// LZSS stream decoder.
// Input stream (s_*): one compressed byte per transaction in s_tdata; s_tlast
// marks the final byte of a block. Bits are parsed most significant first.
// Output stream (m_*): one decoded byte per transaction, m_tuser = 1, with the
// running byte count in the upper tdata bits. After the final input byte an
// end-of-block transaction follows with m_tuser = 0, m_tlast = 1 and the total
// decoded length (saturating) in the upper tdata bits.
// Parsing: an input byte is parsed one bit per cycle, halted during a match copy
// and at a finished literal while the output register is full. Each byte of a
// match copy is a history RAM read, then a write and output; the longest copy
// is 17 bytes. A literal appears on the output in the cycle after its final
// bit; the first byte of a match copy passes a history RAM read and then the
// output register after the bit that ends the match.
// Reset clears the parser, the write slot and the byte count; the history RAM
// is not swept, unwritten slots read as zero by comparing against the fill
// position. The end-of-block transaction returns the block to that state.
// When m_tready is low the decoded byte waits in the output register and the
// parser halts at the next token that needs to emit.
module lzss_stream_decoder_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lzsd_pkg::LitBits-1:0]    s_tdata,   // [7:0] in_byte
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lzsd_pkg::OutDataW-1:0]   m_tdata,   // [7:0] out_byte, [39:8] total_length
    output logic                            m_tuser,   // [0] is_data
    output logic                            m_tlast
);
    import lzsd_pkg::*;

    cmd_t               cmd;
    status_t            status;
    logic [LitBits-1:0] out_byte;
    logic [CountW-1:0]  total_length;

    lzsd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lzsd_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .in_byte      (s_tdata),
        .last_byte    (s_tlast),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_byte     (out_byte),
        .is_data      (m_tuser),
        .out_last     (m_tlast),
        .total_length (total_length)
    );

    assign m_tdata = {total_length, out_byte};

endmodule

[dv/lzss_decode_checker.sv]
module lzss_decode_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [lzsd_pkg::LitBits-1:0]  s_tdata,   // [7:0] in_byte
    input  logic                          s_tlast,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [lzsd_pkg::OutDataW-1:0] m_tdata,   // [7:0] out_byte, [39:8] total_length
    input  logic                          m_tuser,   // [0] is_data
    input  logic                          m_tlast,
    output int                            mismatch_count,
    output int                            outstanding
);
    import lzsd_pkg::*;

    typedef enum logic [1:0] {
        TOK_FLAG    = 2'd0,
        TOK_LITERAL = 2'd1,
        TOK_MATCH   = 2'd2
    } token_phase_e;

    typedef struct packed {
        logic [LitBits-1:0] data;
        logic               is_data;
        logic               last;
        logic [CountW-1:0]  total;
    } decoded_t;

    logic [LitBits-1:0] ring [HistDepth];
    logic [AddrW-1:0]   wr_slot;
    logic [CountW-1:0]  byte_count;
    logic [AccW-1:0]    acc;
    int                 held;
    token_phase_e       phase;
    decoded_t           expected_q[$];
    int                 errors;

    task automatic clear_block();
        for (int i = 0; i < HistDepth; i++)
        begin
            ring[i] = '0;
        end
        wr_slot    = '0;
        byte_count = '0;
        acc        = '0;
        held       = 0;
        phase      = TOK_FLAG;
    endtask

    task automatic write_out(input logic [LitBits-1:0] b);
        ring[wr_slot] = b;
        wr_slot = wr_slot + AddrW'(1);
        if (byte_count != '1)
        begin
            byte_count = byte_count + CountW'(1);
        end
        expected_q.push_back('{data: b, is_data: 1'b1, last: 1'b0, total: byte_count});
    endtask

    // Walk the byte MSB first through the token parser.
    task automatic decode_byte(input logic [LitBits-1:0] b, input logic blk_end);
        logic               bitv;
        logic [LenBits-1:0] len;
        logic [PosBits-1:0] pos;
        logic [AddrW-1:0]   src;
        for (int i = LitBits - 1; i >= 0; i--)
        begin
            bitv = b[i];
            if (phase != TOK_LITERAL && phase != TOK_MATCH)
            begin
                phase = bitv ? TOK_LITERAL : TOK_MATCH;
                acc   = '0;
                held  = 0;
            end
            else
            begin
                acc  = {acc[AccW-2:0], bitv};
                held = held + 1;
                if (phase == TOK_LITERAL)
                begin
                    if (held >= LitBits)
                    begin
                        write_out(acc[LitBits-1:0]);
                        phase = TOK_FLAG;
                        acc   = '0;
                        held  = 0;
                    end
                end
                else if (held >= AccW)
                begin
                    len = acc[LenBits-1:0];
                    pos = acc[AccW-1:LenBits];
                    src = AddrW'(pos - PosBits'(1));
                    for (int k = 0; k < int'(len) + MinMatch; k++)
                    begin
                        write_out(ring[src]);
                        src = src + AddrW'(1);
                    end
                    phase = TOK_FLAG;
                    acc   = '0;
                    held  = 0;
                end
            end
        end
        if (blk_end)
        begin
            expected_q.push_back('{data: '0, is_data: 1'b0, last: 1'b1, total: byte_count});
            clear_block();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        decoded_t exp_item;
        if (!rst_n)
        begin
            clear_block();
            expected_q.delete();
            errors = 0;
            mismatch_count <= 0;
            outstanding    <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                decode_byte(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_q.size() == 0)
                begin
                    errors = errors + 1;
                    if (errors <= 10)
                    begin
                        $display("unexpected output transaction: ",
                                 "byte %02h data %0d last %0d total %0d",
                                 m_tdata[LitBits-1:0], m_tuser, m_tlast,
                                 m_tdata[OutDataW-1:LitBits]);
                    end
                end
                else
                begin
                    exp_item = expected_q.pop_front();
                    if (m_tdata[LitBits-1:0] !== exp_item.data
                        || m_tuser !== exp_item.is_data
                        || m_tlast !== exp_item.last
                        || m_tdata[OutDataW-1:LitBits] !== exp_item.total)
                    begin
                        errors = errors + 1;
                        if (errors <= 10)
                        begin
                            $display("mismatch: expected byte %02h data %0d last %0d total %0d,",
                                     exp_item.data, exp_item.is_data, exp_item.last,
                                     exp_item.total,
                                     " got byte %02h data %0d last %0d total %0d",
                                     m_tdata[LitBits-1:0], m_tuser, m_tlast,
                                     m_tdata[OutDataW-1:LitBits]);
                        end
                    end
                end
            end
            mismatch_count <= errors;
            outstanding    <= expected_q.size();
        end
    end

endmodule

[dv/testbench.sv]
module testbench;
    import lzsd_pkg::*;

    localparam int CycleLimit   = 300000;
    localparam int RandomBytes  = 105;
    localparam int DrainCycles  = 60;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [LitBits-1:0]  s_tdata = '0;
    logic                s_tlast = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OutDataW-1:0] m_tdata;
    logic                m_tuser;
    logic                m_tlast;

    int fail_count;
    int outstanding;
    int cycles = 0;
    int stall_left = 0;
    int sent_bytes = 0;
    int block_written = 0;
    bit sender_idles = 1'b0;
    bit receiver_stalls = 1'b0;
    bit stream_bits[$];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    lzss_stream_decoder_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    lzss_decode_checker decode_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .mismatch_count (fail_count),
        .outstanding    (outstanding)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Drop m_tready at random while receiver_stalls is set.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (receiver_stalls && $urandom_range(0, 6) == 0)
        begin
            stall_left <= $urandom_range(0, 5);
            m_tready   <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_byte(input logic [LitBits-1:0] b, input logic blk_end);
        int gap;
        if (sender_idles && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= blk_end;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sent_bytes++;
    endtask

    task automatic add_bits(input logic [31:0] v, input int n);
        for (int i = n - 1; i >= 0; i--)
        begin
            stream_bits.push_back(v[i]);
        end
    endtask

    task automatic add_literal(input logic [LitBits-1:0] b);
        add_bits(1, 1);
        add_bits(32'(b), LitBits);
        block_written++;
    endtask

    task automatic add_match(input logic [PosBits-1:0] pos, input logic [LenBits-1:0] len);
        add_bits(0, 1);
        add_bits(32'(pos), PosBits);
        add_bits(32'(len), LenBits);
        block_written += int'(len) + MinMatch;
    endtask

    // Pad the bit stream with random bits and send it as one block.
    task automatic send_block();
        logic [LitBits-1:0] b;
        if (stream_bits.size() == 0)
        begin
            add_bits($urandom, LitBits);
        end
        while (stream_bits.size() % LitBits != 0)
        begin
            stream_bits.push_back(1'($urandom_range(0, 1)));
        end
        while (stream_bits.size() > 0)
        begin
            for (int i = LitBits - 1; i >= 0; i--)
            begin
                b[i] = stream_bits.pop_front();
            end
            send_byte(b, stream_bits.size() == 0);
        end
        block_written = 0;
    endtask

    task automatic random_block();
        int ntok;
        int span;
        int chop;
        logic [PosBits-1:0] pos;
        logic [LenBits-1:0] len;
        ntok = $urandom_range(1, 10);
        for (int t = 0; t < ntok; t++)
        begin
            len = LenBits'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                        : $urandom_range(0, 4));
            case ($urandom_range(0, 9))
                0, 1, 2, 3: add_literal(LitBits'($urandom));
                9:          add_match(PosBits'($urandom), len);
                default:
                begin
                    if (block_written > 0 && block_written < HistDepth)
                    begin
                        span = (block_written > HistDepth - 1) ? HistDepth - 1 : block_written;
                        pos  = PosBits'($urandom_range(1, span));
                    end
                    else
                    begin
                        pos = PosBits'($urandom);
                    end
                    add_match(pos, len);
                end
            endcase
        end
        if ($urandom_range(0, 3) == 0)
        begin
            chop = $urandom_range(1, 12);
            while (chop > 0 && stream_bits.size() > 1)
            begin
                void'(stream_bits.pop_back());
                chop--;
            end
        end
        send_block();
    endtask

    task automatic noise_block();
        int n;
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++)
        begin
            send_byte(LitBits'($urandom), i == n - 1);
        end
    endtask

    task automatic wait_drained();
        while (outstanding != 0) @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    initial
    begin
        int start_count;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        sender_idles    <= 1'b1;
        receiver_stalls <= 1'b1;

        // cut-off literal alone in a block
        send_byte(8'hFF, 1'b1);

        // extreme literals, unwritten slots, long overlapping copies
        add_literal(8'h00);
        add_literal(8'hFF);
        add_match(9'd0, 4'd0);
        add_match(9'd1, 4'd15);
        add_match(9'h1FF, 4'd15);
        add_literal(8'hA5);
        add_match(PosBits'(block_written), 4'd3);
        send_block();

        // history must be clear after the end of block
        add_match(9'd1, 4'd3);
        send_block();

        // match cut short by the last byte
        add_literal(8'h5A);
        add_bits(0, 1);
        add_bits(32'h15, 5);
        send_block();

        for (int i = 0; i < 4; i++)
        begin
            send_byte(LitBits'($urandom), i == 3);
        end

        // hold the sender until the block has drained
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait_drained();

        start_count = sent_bytes;
        while (sent_bytes - start_count < RandomBytes)
        begin
            if (sent_bytes - start_count > RandomBytes - 25)
            begin
                sender_idles    <= 1'b0;
                receiver_stalls <= 1'b0;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                sender_idles    <= 1'($urandom_range(0, 1));
                receiver_stalls <= 1'($urandom_range(0, 1));
            end
            if ($urandom_range(0, 4) == 0)
            begin
                noise_block();
            end
            else
            begin
                random_block();
            end
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        wait_drained();
        if (fail_count == 0 && outstanding == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[sim.f]
sv/lzsd_pkg.sv
sv/lzsd_ctrl.sv
sv/lzsd_datapath.sv
sv/lzss_stream_decoder_unit.sv
dv/lzss_decode_checker.sv
dv/testbench.sv
